// ----- src/lcfc_pkg.sv -----
// ----------------------------------------------------------------------------
// lcfc_pkg
// Shared types and constants for the length-prefixed CRC-32 frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfc_pkg;

   // header layout: 2 length bytes then 4 CRC bytes, both big-endian
   localparam logic [2:0]  HDR_BYTES    = 3'd6;
   localparam logic [2:0]  LEN_BYTES    = 3'd2;
   localparam logic [16:0] COUNT_MAX    = 17'h1FFFF;
   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

   // result queue sizing
   localparam int          QUEUE_DEPTH        = 4;
   localparam logic [2:0]  QUEUE_ACCEPT_LIMIT = 3'd2;

   typedef logic [1:0] queue_ptr_type;
   typedef logic [2:0] queue_count_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_SHORT_HEADER = 2'd1,
      STATUS_LENGTH_SHORT = 2'd2,
      STATUS_CRC_MISMATCH = 2'd3
   } frame_status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type    item_kind;
      logic [7:0]       payload_byte;
      frame_status_type frame_status;
      logic [15:0]      declared_length;
      logic             run_last;
   } result_type;

   // results written into the queue in one cycle, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // byte-wide reflected CRC-32 update
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- src/lcfc_req_if.sv -----
// ----------------------------------------------------------------------------
// lcfc_req_if
// Received byte channel: one frame byte and its end-of-frame mark per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- src/lcfc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lcfc_rsp_if
// Result channel: payload byte items and end-of-frame status items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcfc_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  payload_byte;
   logic [1:0]  frame_status;
   logic [15:0] declared_length;
   logic        run_last;

   modport source (output valid, output item_kind, output payload_byte, output frame_status,
                   output declared_length, output run_last, input ready);
   modport sink   (input valid, input item_kind, input payload_byte, input frame_status,
                   input declared_length, input run_last, output ready);
endinterface

`default_nettype wire

// ----- src/lcfc_result_queue.sv -----
// ----------------------------------------------------------------------------
// lcfc_result_queue
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfc_result_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lcfc_pkg::push_type   push,
   output logic                      space_ok,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output lcfc_pkg::result_type      out_item
);

   lcfc_pkg::result_type      entry_ff [lcfc_pkg::QUEUE_DEPTH];
   lcfc_pkg::queue_ptr_type   wr_ptr_ff, wr_ptr_in, wr_next_ptr;
   lcfc_pkg::queue_ptr_type   rd_ptr_ff, rd_ptr_in;
   lcfc_pkg::queue_count_type count_ff, count_in;
   logic                      pop;

   // head of queue and handshake
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign space_ok  = (count_ff <= lcfc_pkg::QUEUE_ACCEPT_LIMIT);

   // pointer and fill arithmetic
   always_comb begin
      wr_next_ptr = wr_ptr_ff + 2'd1;
      wr_ptr_in   = wr_ptr_ff + push.count;
      rd_ptr_in   = rd_ptr_ff + {1'b0, pop};
      count_in    = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next_ptr] <= push.second;
      end
   end

endmodule

`default_nettype wire

// ----- src/length_crc32_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// length_crc32_frame_checker_unit
// Checks length-prefixed frames with a CRC-32 header field, byte by byte.
// ----------------------------------------------------------------------------
// A result is registered into the result queue when its byte is taken.
// One byte per cycle unless held off; a byte-wide CRC update sits between the
//   input handshake and a four-entry result queue read once per cycle.
// A frame-end byte that also carries payload gives two results; input is
//   held off while the queue has under two free entries.
// Reset (synchronous): frame state cleared, CRC set to all ones, queue empty.
`default_nettype none

module length_crc32_frame_checker_unit (
   input  wire logic clock,
   input  wire logic reset,
   lcfc_req_if.sink  req_ch,
   lcfc_rsp_if.source rsp_ch
);

   logic [2:0]  header_index_ff,  header_index_in;
   logic [15:0] length_value_ff,  length_value_in;
   logic [31:0] expected_crc_ff,  expected_crc_in;
   logic [31:0] running_crc_ff,   running_crc_in;
   logic [16:0] payload_count_ff, payload_count_in;

   logic [2:0]  idx_nxt;
   logic [15:0] len_nxt;
   logic [31:0] exp_nxt, crc_nxt;
   logic [16:0] cnt_nxt;
   logic        req_fire, in_header, in_length, emit_payload;
   logic        space_ok, rsp_valid;

   lcfc_pkg::frame_status_type status;
   lcfc_pkg::result_type       payload_res, status_res, out_item;
   lcfc_pkg::push_type         push;

   assign req_ch.ready = space_ok;
   assign req_fire     = req_ch.valid && space_ok;
   assign in_header    = (header_index_ff != lcfc_pkg::HDR_BYTES);
   assign in_length    = ({1'b0, length_value_ff} > payload_count_ff);
   assign emit_payload = !in_header && in_length;

   // frame state after this byte
   always_comb begin
      idx_nxt = header_index_ff;
      len_nxt = length_value_ff;
      exp_nxt = expected_crc_ff;
      crc_nxt = running_crc_ff;
      cnt_nxt = payload_count_ff;
      if (in_header) begin
         if (header_index_ff < lcfc_pkg::LEN_BYTES) begin
            len_nxt = {length_value_ff[7:0], req_ch.data_byte};
         end else begin
            exp_nxt = {expected_crc_ff[23:0], req_ch.data_byte};
         end
         idx_nxt = header_index_ff + 3'd1;
      end else begin
         if (in_length) begin
            crc_nxt = lcfc_pkg::crc_fold(running_crc_ff, req_ch.data_byte);
         end
         if (payload_count_ff != lcfc_pkg::COUNT_MAX) begin
            cnt_nxt = payload_count_ff + 17'd1;
         end
      end
   end

   // end-of-frame verdict, in priority order
   always_comb begin
      priority if (idx_nxt != lcfc_pkg::HDR_BYTES) begin
         status = lcfc_pkg::STATUS_SHORT_HEADER;
      end else if ({1'b0, len_nxt} > cnt_nxt) begin
         status = lcfc_pkg::STATUS_LENGTH_SHORT;
      end else if ((crc_nxt ^ lcfc_pkg::CRC_INIT) != exp_nxt) begin
         status = lcfc_pkg::STATUS_CRC_MISMATCH;
      end else begin
         status = lcfc_pkg::STATUS_OK;
      end
   end

   // result items for this byte
   always_comb begin
      payload_res.item_kind       = lcfc_pkg::KIND_PAYLOAD;
      payload_res.payload_byte    = req_ch.data_byte;
      payload_res.frame_status    = lcfc_pkg::STATUS_OK;
      payload_res.declared_length = length_value_ff;
      payload_res.run_last        = !req_ch.frame_end;

      status_res.item_kind        = lcfc_pkg::KIND_STATUS;
      status_res.payload_byte     = 8'd0;
      status_res.frame_status     = status;
      status_res.declared_length  = (status == lcfc_pkg::STATUS_SHORT_HEADER) ? 16'd0 : len_nxt;
      status_res.run_last         = 1'b1;

      push.count  = 2'd0;
      push.first  = payload_res;
      push.second = status_res;
      if (req_fire) begin
         unique case ({emit_payload, req_ch.frame_end})
            2'b11:   push.count = 2'd2;
            2'b10:   push.count = 2'd1;
            2'b01: begin
               push.count = 2'd1;
               push.first = status_res;
            end
            default: push.count = 2'd0;
         endcase
      end
   end

   // register update; a frame end returns to the reset state
   always_comb begin
      header_index_in  = header_index_ff;
      length_value_in  = length_value_ff;
      expected_crc_in  = expected_crc_ff;
      running_crc_in   = running_crc_ff;
      payload_count_in = payload_count_ff;
      if (req_fire) begin
         if (req_ch.frame_end) begin
            header_index_in  = '0;
            length_value_in  = '0;
            expected_crc_in  = '0;
            running_crc_in   = lcfc_pkg::CRC_INIT;
            payload_count_in = '0;
         end else begin
            header_index_in  = idx_nxt;
            length_value_in  = len_nxt;
            expected_crc_in  = exp_nxt;
            running_crc_in   = crc_nxt;
            payload_count_in = cnt_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff  <= '0;
         length_value_ff  <= '0;
         expected_crc_ff  <= '0;
         running_crc_ff   <= lcfc_pkg::CRC_INIT;
         payload_count_ff <= '0;
      end else begin
         header_index_ff  <= header_index_in;
         length_value_ff  <= length_value_in;
         expected_crc_ff  <= expected_crc_in;
         running_crc_ff   <= running_crc_in;
         payload_count_ff <= payload_count_in;
      end
   end

   // result queue
   lcfc_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.item_kind       = out_item.item_kind;
   assign rsp_ch.payload_byte    = out_item.payload_byte;
   assign rsp_ch.frame_status    = out_item.frame_status;
   assign rsp_ch.declared_length = out_item.declared_length;
   assign rsp_ch.run_last        = out_item.run_last;

   // checks
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      header_index_ff <= lcfc_pkg::HDR_BYTES)
      else $error("header index beyond header length");

   a_count_after_header: assert property (@(posedge clock) disable iff (reset)
      (payload_count_ff != '0) |-> (header_index_ff == lcfc_pkg::HDR_BYTES))
      else $error("payload counted before header complete");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.frame_end) |=>
         (header_index_ff == '0 && running_crc_ff == lcfc_pkg::CRC_INIT))
      else $error("frame state not restarted after frame end");

   a_end_gives_status: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.frame_end) |=> rsp_ch.valid)
      else $error("no result pending after frame end");

endmodule

`default_nettype wire

// ----- dv/tb_length_crc32_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// tb_length_crc32_frame_checker_unit
// Self-checking bench for the length-prefixed CRC-32 frame checker. Frames
// are built with a correct or a damaged header and sent byte by byte. A
// tracker object mirrors the header, length and CRC state and predicts every
// payload item and status item. Both channels idle at random, and the result
// side is held off for long stretches so that the result queue fills.
// ----------------------------------------------------------------------------

module tb_length_crc32_frame_checker_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 800;
   localparam int unsigned CYCLE_LIMIT  = 1_500_000;
   localparam int unsigned HOLD_OFF     = 300;
   localparam int unsigned DRAIN_CYCLES = 20;

   // Mirrors the frame state and queues the items each received byte gives
   class frame_check_tracker;
      logic [2:0]  hdr_taken;
      logic [15:0] len_field;
      logic [31:0] crc_field;
      logic [31:0] crc_acc;
      logic [16:0] bytes_after_hdr;
      lcfc_pkg::result_type due_outputs[$];
      int unsigned faults;

      function new();
         faults = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         hdr_taken       = '0;
         len_field       = '0;
         crc_field       = '0;
         crc_acc         = lcfc_pkg::CRC_INIT;
         bytes_after_hdr = '0;
      endfunction

      // reflected CRC-32, one byte, LSB first
      static function logic [31:0] crc_byte_update(input logic [31:0] crc,
                                                   input logic [7:0] b);
         logic [31:0] c;
         c = crc ^ {24'd0, b};
         repeat (8) c = c[0] ? ((c >> 1) ^ lcfc_pkg::CRC_POLY) : (c >> 1);
         return c;
      endfunction

      function void take_byte(input logic [7:0] b, input logic fe);
         lcfc_pkg::result_type r;
         // header: length first, then the CRC field, both big-endian
         if (hdr_taken < lcfc_pkg::HDR_BYTES) begin
            if (hdr_taken < lcfc_pkg::LEN_BYTES) begin
               len_field = {len_field[7:0], b};
            end else begin
               crc_field = {crc_field[23:0], b};
            end
            hdr_taken++;
         end else begin
            // payload within the declared length is passed on
            if ({1'b0, len_field} > bytes_after_hdr) begin
               crc_acc           = crc_byte_update(crc_acc, b);
               r.item_kind       = lcfc_pkg::KIND_PAYLOAD;
               r.payload_byte    = b;
               r.frame_status    = lcfc_pkg::STATUS_OK;
               r.declared_length = len_field;
               r.run_last        = !fe;
               due_outputs.push_back(r);
            end
            if (bytes_after_hdr != lcfc_pkg::COUNT_MAX) bytes_after_hdr++;
         end
         // verdict on the closing byte
         if (fe) begin
            r.item_kind    = lcfc_pkg::KIND_STATUS;
            r.payload_byte = '0;
            r.run_last     = 1'b1;
            if (hdr_taken < lcfc_pkg::HDR_BYTES) begin
               r.frame_status    = lcfc_pkg::STATUS_SHORT_HEADER;
               r.declared_length = '0;
            end else begin
               r.declared_length = len_field;
               if ({1'b0, len_field} > bytes_after_hdr) begin
                  r.frame_status = lcfc_pkg::STATUS_LENGTH_SHORT;
               end else if (~crc_acc != crc_field) begin
                  r.frame_status = lcfc_pkg::STATUS_CRC_MISMATCH;
               end else begin
                  r.frame_status = lcfc_pkg::STATUS_OK;
               end
            end
            due_outputs.push_back(r);
            clear_frame();
         end
      endfunction

      function void match_output(input lcfc_pkg::result_type got);
         lcfc_pkg::result_type want;
         if (due_outputs.size() == 0) begin
            $error("unexpected item: kind %0d byte %0h status %0d length %0d",
                   got.item_kind, got.payload_byte, got.frame_status, got.declared_length);
            faults++;
            return;
         end
         want = due_outputs.pop_front();
         if (got.item_kind !== want.item_kind) begin
            $error("item_kind: expected %0d, got %0d", want.item_kind, got.item_kind);
            faults++;
         end
         if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
            faults++;
         end
         if (got.frame_status !== want.frame_status) begin
            $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
            faults++;
         end
         if (got.declared_length !== want.declared_length) begin
            $error("declared_length: expected %0d, got %0d",
                   want.declared_length, got.declared_length);
            faults++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
            faults++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lcfc_req_if req_bus();
   lcfc_rsp_if rsp_bus();

   length_crc32_frame_checker_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   frame_check_tracker tracker = new();

   logic [7:0]  body_buf[$];
   logic [7:0]  frame_buf[$];
   bit          src_idle  = 1'b1;
   int unsigned bytes_sent = 0;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // header from body_buf; the CRC covers only bytes inside the length
   function automatic void assemble_frame(input logic [15:0] len_hdr,
                                          input logic [31:0] crc_flip);
      logic [31:0] crc;
      crc = lcfc_pkg::CRC_INIT;
      for (int i = 0; i < body_buf.size() && i < len_hdr; i++) begin
         crc = frame_check_tracker::crc_byte_update(crc, body_buf[i]);
      end
      crc = ~crc ^ crc_flip;
      frame_buf = '{len_hdr[15:8], len_hdr[7:0], crc[31:24], crc[23:16], crc[15:8], crc[7:0]};
      foreach (body_buf[i]) frame_buf.push_back(body_buf[i]);
   endfunction

   function automatic void fill_body(input int unsigned n);
      body_buf.delete();
      repeat (n) body_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   // offer one byte, after a random gap while src_idle is set, and wait for it to be taken
   task automatic offer_byte(input logic [7:0] b, input logic fe);
      int unsigned gap;
      gap = !src_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.frame_end <= fe;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.take_byte(b, fe);
      bytes_sent++;
   endtask

   // first upto bytes of frame_buf, frame end on the last one sent
   task automatic send_frame(input int unsigned upto);
      for (int unsigned i = 0; i < upto; i++) begin
         offer_byte(frame_buf[i], i == upto - 1);
      end
   endtask

   // stimulus
   initial begin : byte_source
      int unsigned pick;
      int unsigned n;
      int unsigned extra;
      int unsigned stop_at;
      logic [15:0] len;
      logic [31:0] flip;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.frame_end <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero length: CRC of the empty message, then an ignored byte
      body_buf = '{8'h5A};
      assemble_frame(16'd0, 32'd0);
      send_frame(7);
      // byte extremes, frame ends on a payload byte
      body_buf = '{8'h00, 8'hFF};
      assemble_frame(16'd2, 32'd0);
      send_frame(8);
      // CRC field damaged
      body_buf = '{8'hA5};
      assemble_frame(16'd1, 32'h8000_0000);
      send_frame(7);
      // largest length, frame ends on the last header byte
      body_buf.delete();
      assemble_frame(16'hFFFF, 32'd0);
      send_frame(6);
      // frame ends on its first byte
      send_frame(1);

      // random frames, mostly well formed
      stop_at = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < stop_at) begin
         src_idle = ($urandom_range(0, 3) != 0);
         pick     = $urandom_range(0, 99);
         n        = $urandom_range(0, 12);
         extra    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
         flip     = 32'd0;
         len      = 16'(n);
         if (pick < 60) begin
            fill_body(n + extra);
         end else if (pick < 72) begin
            flip = $urandom();
            if (flip == 32'd0) flip = 32'd1;
            fill_body(n + extra);
         end else if (pick < 82) begin
            len = 16'(n + $urandom_range(1, 3));
            fill_body(n);
         end else if (pick < 90) begin
            len = 16'($urandom_range(0, 65535));
            fill_body(n);
         end
         if (pick < 90) begin
            assemble_frame(len, flip);
            send_frame(frame_buf.size());
         end else if (pick < 95) begin
            // header cut short
            fill_body(0);
            len = 16'($urandom_range(0, 65535));
            assemble_frame(len, $urandom());
            send_frame($urandom_range(1, 5));
         end else begin
            // noise: random bytes, random frame ends
            repeat ($urandom_range(1, 10)) begin
               offer_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
         end
      end
      req_bus.valid <= 1'b0;

      while (tracker.due_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.faults == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result side: random stalls, two long hold-offs
   initial begin : result_sink
      int unsigned wait_cycles;
      int unsigned taken;
      bit          idle;
      lcfc_pkg::result_type got;

      taken = 0;
      idle  = 1'b1;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 40 == 0) idle = ($urandom_range(0, 3) != 0);
         if (taken == 120 || taken == 450) begin
            wait_cycles = HOLD_OFF;
         end else begin
            wait_cycles = !idle ? 0 : $urandom_range(0, 7);
         end
         if (wait_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got = {rsp_bus.item_kind, rsp_bus.payload_byte, rsp_bus.frame_status,
                rsp_bus.declared_length, rsp_bus.run_last};
         tracker.match_output(got);
         taken++;
      end
   end

   // watchdog
   initial begin : cycle_guard
      int unsigned cycles;
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
